// ===== rtl/srgb_gray_mosaic_core_macros.svh =====
// Assertion macros shared by the gray mosaic RTL.
`ifndef SRGB_GRAY_MOSAIC_CORE_MACROS_SVH
`define SRGB_GRAY_MOSAIC_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Check that the consequent holds in the same cycle as the antecedent.
`define SGM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Check that the consequent holds in the cycle after the antecedent.
`define SGM_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SGM_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define SGM_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/sgm_pkg.sv =====
// Package: frame geometry, payload types and sRGB conversion tables.
`default_nettype none

package sgm_pkg;

    // Frame and block geometry
    localparam int FRAME_WIDTH  = 352;
    localparam int FRAME_HEIGHT = 288;
    localparam int BLOCK_SIZE   = 8;
    localparam int BLOCK_COLS   = (FRAME_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE;

    localparam int COL_W = $clog2(FRAME_WIDTH);
    localparam int ROW_W = $clog2(FRAME_HEIGHT);
    localparam int BLK_W = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
    localparam int BC_W  = (BLOCK_COLS > 1) ? $clog2(BLOCK_COLS) : 1;

    // Fixed-point widths: linear values are Q16 in 0..65536
    localparam int LIN_W  = 17;
    localparam int WGT_W  = 16;
    localparam int PROD_W = LIN_W + WGT_W;
    localparam int SUM_W  = PROD_W + 1;

    // Rec.709 luminance weights in Q16
    localparam logic [WGT_W-1:0] W_RED   = 16'd13933;
    localparam logic [WGT_W-1:0] W_GREEN = 16'd46871;
    localparam logic [WGT_W-1:0] W_BLUE  = 16'd4732;
    localparam logic [SUM_W-1:0] ROUND_HALF = 34'd32768;

    // Input and result beats
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_t;

    typedef struct packed {
        logic [7:0] gray;
        logic       frame_last;
    } res_t;

    // Position info that travels with each pixel through the pipeline
    typedef struct packed {
        logic            compute;
        logic [BC_W-1:0] bc;
        logic            last;
    } tag_t;

    typedef logic [255:0][LIN_W-1:0] lin_tab_t;
    typedef logic [254:0][LIN_W-1:0] thr_tab_t;

    // round(65536 * (num/den)^2.4), half up, by exact wide-integer binary search
    function automatic logic [LIN_W-1:0] pow_q16(input logic [19:0] num,
                                                 input logic [19:0] den);
        logic [383:0] rhs;
        logic [383:0] d12;
        logic [383:0] tmp;
        logic [17:0]  lo;
        logic [17:0]  hi;
        logic [17:0]  mid;
        rhs = 384'd1;
        d12 = 384'd1;
        for (int i = 0; i < 12; i++) begin
            rhs = rhs * 384'(num);
            d12 = d12 * 384'(den);
        end
        rhs = rhs << 85;
        lo  = 18'd0;
        hi  = 18'd65536;
        mid = 18'd0;
        for (int it = 0; it < 17; it++) begin
            if (lo < hi) begin
                mid = (lo + hi + 18'd1) >> 1;
                tmp = d12;
                for (int i = 0; i < 5; i++) begin
                    tmp = tmp * 384'((19'(mid) << 1) - 19'd1);
                end
                if (tmp <= rhs) begin
                    lo = mid;
                end else begin
                    hi = mid - 18'd1;
                end
            end
        end
        return lo[LIN_W-1:0];
    endfunction

    // Linear value of each sRGB code
    function automatic lin_tab_t build_lin_tab();
        lin_tab_t    tab;
        logic [63:0] q;
        tab = '0;
        for (int k = 0; k < 256; k++) begin
            if (k <= 10) begin
                q = (64'(k) * 64'd13107200 + 64'd329460) / 64'd658920;
                tab[8'(k)] = q[LIN_W-1:0];
            end else begin
                tab[8'(k)] = pow_q16(20'(1000 * k + 14025), 20'd269025);
            end
        end
        return tab;
    endfunction

    // Linear value halfway between adjacent sRGB codes
    function automatic thr_tab_t build_thr_tab();
        thr_tab_t    tab;
        logic [63:0] q;
        tab = '0;
        for (int k = 0; k < 255; k++) begin
            if (k <= 9) begin
                q = (64'(2 * k + 1) * 64'd13107200 + 64'd658920) / 64'd1317840;
                tab[8'(k)] = q[LIN_W-1:0];
            end else begin
                tab[8'(k)] = pow_q16(20'(2000 * k + 29050), 20'd538050);
            end
        end
        return tab;
    endfunction

    localparam lin_tab_t LIN_TAB = build_lin_tab();
    localparam thr_tab_t THR_TAB = build_thr_tab();

endpackage

`default_nettype wire

// ===== rtl/srgb_gray_mosaic_core.sv =====
// Top level: raster position tracking around the luminance pipeline and line store.
//
// Takes RGB pixels in raster order on the s_ channel (s_valid/s_ready, s_data) and
// returns one beat per pixel on the m_ channel (m_valid/m_ready, m_data). Each
// result carries the gamma-correct Rec.709 gray of the top-left pixel of its
// 8x8 block; frame_last marks the last pixel of a 352x288 frame.
// Path: an accepted pixel reaches m_ through six pipeline stages and then the
// output register.
// Throughput: one pixel per cycle unless m_ready stalls the output; each stage
// is a register, a single table lookup, multiply, add or 15-way threshold compare.
// Reset: position counters return to the first pixel of a frame and the
// pipeline empties. Line store entries need no clearing: the top-left pixel of
// a block always writes its entry before any later pixel of that block reads it.
// Stall: when m_ready is low, beats collect in empty stages; s_ready drops only
// once all seven registers hold a beat.
`default_nettype none
`include "srgb_gray_mosaic_core_macros.svh"

module srgb_gray_mosaic_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire sgm_pkg::pix_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output sgm_pkg::res_t      m_data
);

    logic [sgm_pkg::COL_W-1:0] col_reg, col_next;
    logic [sgm_pkg::ROW_W-1:0] row_reg, row_next;
    logic [sgm_pkg::BLK_W-1:0] cph_reg, cph_next;
    logic [sgm_pkg::BLK_W-1:0] rph_reg, rph_next;
    logic [sgm_pkg::BC_W-1:0]  bc_reg, bc_next;

    logic          s_fire;
    logic          col_end, row_end, cph_end, rph_end;
    sgm_pkg::tag_t pix_tag;

    logic          pipe_valid;
    logic          pipe_ready;
    logic [7:0]    pipe_gray;
    sgm_pkg::tag_t pipe_tag;

    assign s_fire  = s_valid & s_ready;
    assign col_end = col_reg == sgm_pkg::COL_W'(sgm_pkg::FRAME_WIDTH - 1);
    assign row_end = row_reg == sgm_pkg::ROW_W'(sgm_pkg::FRAME_HEIGHT - 1);
    assign cph_end = cph_reg == sgm_pkg::BLK_W'(sgm_pkg::BLOCK_SIZE - 1);
    assign rph_end = rph_reg == sgm_pkg::BLK_W'(sgm_pkg::BLOCK_SIZE - 1);

    // Tag each pixel with its block column and whether it opens a block
    assign pix_tag.compute = (cph_reg == '0) && (rph_reg == '0);
    assign pix_tag.bc      = bc_reg;
    assign pix_tag.last    = col_end & row_end;

    // Advance raster position on each accepted beat
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        cph_next = cph_reg;
        rph_next = rph_reg;
        bc_next  = bc_reg;
        if (s_fire) begin
            if (col_end) begin
                col_next = '0;
                cph_next = '0;
                bc_next  = '0;
                if (row_end) begin
                    row_next = '0;
                    rph_next = '0;
                end else begin
                    row_next = row_reg + sgm_pkg::ROW_W'(1);
                    rph_next = rph_end ? '0 : rph_reg + sgm_pkg::BLK_W'(1);
                end
            end else begin
                col_next = col_reg + sgm_pkg::COL_W'(1);
                if (cph_end) begin
                    cph_next = '0;
                    bc_next  = bc_reg + sgm_pkg::BC_W'(1);
                end else begin
                    cph_next = cph_reg + sgm_pkg::BLK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            cph_reg <= '0;
            rph_reg <= '0;
            bc_reg  <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            cph_reg <= cph_next;
            rph_reg <= rph_next;
            bc_reg  <= bc_next;
        end
    end

    sgm_luma_pipe u_luma_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_pix    (s_data),
        .in_tag    (pix_tag),
        .out_valid (pipe_valid),
        .out_ready (pipe_ready),
        .out_gray  (pipe_gray),
        .out_tag   (pipe_tag)
    );

    sgm_line_store u_line_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (pipe_valid),
        .in_ready (pipe_ready),
        .in_gray  (pipe_gray),
        .in_tag   (pipe_tag),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    `SGM_ASSERT_NXT(a_frame_wraps, aclk, aresetn, s_fire && pix_tag.last,
        (col_reg == '0) && (row_reg == '0) && (bc_reg == '0),
        "raster position did not wrap after the last pixel")

endmodule

`default_nettype wire

// ===== rtl/sgm_luma_pipe.sv =====
// Luminance pipeline: sRGB to linear, weighted sum, back to an sRGB gray code.
`default_nettype none
`include "srgb_gray_mosaic_core_macros.svh"

module sgm_luma_pipe (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire sgm_pkg::pix_t in_pix,
    input  wire sgm_pkg::tag_t in_tag,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_gray,
    output sgm_pkg::tag_t      out_tag
);

    logic [5:0] vld_reg;
    logic [5:0] stg_rdy;

    sgm_pkg::pix_t pix1_reg;
    sgm_pkg::tag_t tag1_reg;
    logic [sgm_pkg::LIN_W-1:0] lin_r_reg, lin_g_reg, lin_b_reg;
    sgm_pkg::tag_t tag2_reg;
    logic [sgm_pkg::PROD_W-1:0] prod_r_reg, prod_g_reg, prod_b_reg;
    sgm_pkg::tag_t tag3_reg;
    logic [sgm_pkg::LIN_W-1:0] luma4_reg;
    sgm_pkg::tag_t tag4_reg;
    logic [sgm_pkg::LIN_W-1:0] luma5_reg;
    logic [3:0] hi_reg;
    sgm_pkg::tag_t tag5_reg;
    logic [7:0] gray6_reg;
    sgm_pkg::tag_t tag6_reg;

    logic [sgm_pkg::SUM_W-1:0] sum_next;
    logic [3:0] hi_next;
    logic [3:0] lo_next;
    logic [7:0] lo_idx;

    // A stage loads when it is empty or its beat moves on
    assign stg_rdy[5] = ~vld_reg[5] | out_ready;
    assign stg_rdy[4] = ~vld_reg[4] | stg_rdy[5];
    assign stg_rdy[3] = ~vld_reg[3] | stg_rdy[4];
    assign stg_rdy[2] = ~vld_reg[2] | stg_rdy[3];
    assign stg_rdy[1] = ~vld_reg[1] | stg_rdy[2];
    assign stg_rdy[0] = ~vld_reg[0] | stg_rdy[1];
    assign in_ready   = stg_rdy[0];

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (stg_rdy[0]) vld_reg[0] <= in_valid;
            if (stg_rdy[1]) vld_reg[1] <= vld_reg[0];
            if (stg_rdy[2]) vld_reg[2] <= vld_reg[1];
            if (stg_rdy[3]) vld_reg[3] <= vld_reg[2];
            if (stg_rdy[4]) vld_reg[4] <= vld_reg[3];
            if (stg_rdy[5]) vld_reg[5] <= vld_reg[4];
        end
    end

    // Weighted sum, rounded back to Q16
    assign sum_next = sgm_pkg::SUM_W'(prod_r_reg) + sgm_pkg::SUM_W'(prod_g_reg)
                    + sgm_pkg::SUM_W'(prod_b_reg) + sgm_pkg::ROUND_HALF;

    // Count coarse thresholds at or below the luminance: high nibble of the code
    always_comb begin
        hi_next = 4'd0;
        for (int j = 1; j < 16; j++) begin
            if (sgm_pkg::THR_TAB[8'(j * 16 - 1)] <= luma4_reg) hi_next = hi_next + 4'd1;
        end
    end

    // Count fine thresholds inside the selected group: low nibble of the code
    always_comb begin
        lo_next = 4'd0;
        lo_idx  = 8'd0;
        for (int j = 1; j < 16; j++) begin
            lo_idx = {hi_reg, 4'(j)} - 8'd1;
            if (sgm_pkg::THR_TAB[lo_idx] <= luma5_reg) lo_next = lo_next + 4'd1;
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (stg_rdy[0]) begin
            pix1_reg <= in_pix;
            tag1_reg <= in_tag;
        end
        if (stg_rdy[1]) begin
            lin_r_reg <= sgm_pkg::LIN_TAB[pix1_reg.red];
            lin_g_reg <= sgm_pkg::LIN_TAB[pix1_reg.green];
            lin_b_reg <= sgm_pkg::LIN_TAB[pix1_reg.blue];
            tag2_reg  <= tag1_reg;
        end
        if (stg_rdy[2]) begin
            prod_r_reg <= sgm_pkg::PROD_W'(sgm_pkg::W_RED) * sgm_pkg::PROD_W'(lin_r_reg);
            prod_g_reg <= sgm_pkg::PROD_W'(sgm_pkg::W_GREEN) * sgm_pkg::PROD_W'(lin_g_reg);
            prod_b_reg <= sgm_pkg::PROD_W'(sgm_pkg::W_BLUE) * sgm_pkg::PROD_W'(lin_b_reg);
            tag3_reg   <= tag2_reg;
        end
        if (stg_rdy[3]) begin
            luma4_reg <= sum_next[32:16];
            tag4_reg  <= tag3_reg;
        end
        if (stg_rdy[4]) begin
            luma5_reg <= luma4_reg;
            hi_reg    <= hi_next;
            tag5_reg  <= tag4_reg;
        end
        if (stg_rdy[5]) begin
            gray6_reg <= {hi_reg, lo_next};
            tag6_reg  <= tag5_reg;
        end
    end

    assign out_valid = vld_reg[5];
    assign out_gray  = gray6_reg;
    assign out_tag   = tag6_reg;

    `SGM_ASSERT_IMP(a_full_when_blocked, aclk, aresetn, !in_ready, &vld_reg,
        "input blocked while a pipeline stage is empty")
    `SGM_ASSERT_NXT(a_last_stage_holds, aclk, aresetn, vld_reg[5] && !out_ready,
        vld_reg[5] && $stable(gray6_reg), "last stage changed while stalled")

endmodule

`default_nettype wire

// ===== rtl/sgm_line_store.sv =====
// Block-column gray store and the result output register.
`default_nettype none
`include "srgb_gray_mosaic_core_macros.svh"

module sgm_line_store (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    in_gray,
    input  wire sgm_pkg::tag_t in_tag,
    output logic               m_valid,
    input  wire logic          m_ready,
    output sgm_pkg::res_t      m_data
);

    logic [7:0]    gray_mem [sgm_pkg::BLOCK_COLS];
    logic          out_vld_reg;
    sgm_pkg::res_t res_reg;
    logic          in_fire;

    assign in_ready = ~out_vld_reg | m_ready;
    assign in_fire  = in_valid & in_ready;

    // Hold the output beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (in_ready) begin
            out_vld_reg <= in_valid;
        end
    end

    // Store the top-left gray of a block; repeat it for the rest of the block
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            if (in_tag.compute) begin
                gray_mem[in_tag.bc] <= in_gray;
                res_reg.gray        <= in_gray;
            end else begin
                res_reg.gray        <= gray_mem[in_tag.bc];
            end
            res_reg.frame_last <= in_tag.last;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = res_reg;

    `SGM_ASSERT_NXT(a_top_left_passes, aclk, aresetn, in_fire && in_tag.compute,
        m_data.gray == $past(in_gray), "top-left gray not passed to the output")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for srgb_gray_mosaic_core: self-checking gray mosaic stream test.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT  = 1000;
    localparam int unsigned DRAIN_CYCLES = 20;

    // Rec.709 weights in Q16
    localparam longint unsigned WR = 13933;
    localparam longint unsigned WG = 46871;
    localparam longint unsigned WB = 4732;

    typedef enum int {PACE_BURST, PACE_SPARSE, PACE_RANDOM} pace_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    sgm_pkg::pix_t s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    sgm_pkg::res_t m_data;

    pace_t pace = PACE_BURST;
    int unsigned fail_count = 0;
    int unsigned stall_cycles = 0;

    // Gamma tables: linear value per code, and linear midpoints between codes
    logic [16:0] lin_q16 [256];
    logic [16:0] mid_q16 [255];

    // Raster position and per-block-column gray store of the prediction
    int unsigned pix_col = 0;
    int unsigned pix_row = 0;
    logic [7:0]  block_gray [sgm_pkg::BLOCK_COLS];

    sgm_pkg::res_t mosaic_q [$];

    // Codes near the ends of the range, around the linear/power knee, and mid-scale
    logic [7:0] edge_codes [8] = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd9, 8'd10, 8'd11, 8'd128};

    srgb_gray_mosaic_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // True when (2r-1)^5 * den^12 <= num^12 * 2^85, i.e. r-1/2 <= 65536*(num/den)^2.4
    function automatic bit gamma_fits(int unsigned r, int unsigned num, int unsigned den);
        logic [383:0] lhs;
        logic [383:0] rhs;
        lhs = 384'd1;
        rhs = 384'd1;
        for (int i = 0; i < 12; i++) begin
            lhs = lhs * 384'(den);
            rhs = rhs * 384'(num);
        end
        for (int i = 0; i < 5; i++) begin
            lhs = lhs * 384'(2 * r - 1);
        end
        return lhs <= (rhs << 85);
    endfunction

    // Start from a floating estimate, then settle it exactly
    function automatic logic [16:0] gamma_q16(int unsigned num, int unsigned den);
        real         est;
        int unsigned r;
        est = 65536.0 * $pow(real'(num) / real'(den), 2.4);
        r = $rtoi(est + 0.5);
        if (r < 1) r = 1;
        while (gamma_fits(r + 1, num, den)) r++;
        while (r > 1 && !gamma_fits(r, num, den)) r--;
        return 17'(r);
    endfunction

    task automatic build_gamma_tables();
        for (int k = 0; k < 256; k++) begin
            if (k <= 10) lin_q16[k] = 17'((k * 655360 + 16473) / 32946);
            else         lin_q16[k] = gamma_q16(1000 * k + 14025, 269025);
        end
        for (int k = 0; k < 255; k++) begin
            if (k <= 9) mid_q16[k] = 17'(((2 * k + 1) * 327680 + 16473) / 32946);
            else        mid_q16[k] = gamma_q16(2000 * k + 29050, 538050);
        end
    endtask

    function automatic logic [7:0] luma_gray(sgm_pkg::pix_t p);
        longint unsigned acc;
        longint unsigned lum;
        int unsigned     n;
        acc = WR * lin_q16[p.red] + WG * lin_q16[p.green] + WB * lin_q16[p.blue];
        lum = (acc + 32768) >> 16;
        n = 0;
        for (int k = 0; k < 255; k++) begin
            if (mid_q16[k] <= lum) n++;
        end
        return 8'(n);
    endfunction

    function automatic bit at_block_corner();
        return (pix_row % sgm_pkg::BLOCK_SIZE == 0) && (pix_col % sgm_pkg::BLOCK_SIZE == 0);
    endfunction

    // Advance the raster position by one pixel and return its mosaic beat
    function automatic sgm_pkg::res_t mosaic_step(sgm_pkg::pix_t p);
        int unsigned   bc;
        sgm_pkg::res_t r;
        bc = pix_col / sgm_pkg::BLOCK_SIZE;
        if (bc >= sgm_pkg::BLOCK_COLS) bc = sgm_pkg::BLOCK_COLS - 1;
        if (at_block_corner()) block_gray[bc] = luma_gray(p);
        r.gray       = block_gray[bc];
        r.frame_last = (pix_col == sgm_pkg::FRAME_WIDTH - 1)
                    && (pix_row == sgm_pkg::FRAME_HEIGHT - 1);
        pix_col++;
        if (pix_col >= sgm_pkg::FRAME_WIDTH) begin
            pix_col = 0;
            pix_row++;
            if (pix_row >= sgm_pkg::FRAME_HEIGHT) pix_row = 0;
        end
        return r;
    endfunction

    function automatic int unsigned draw_gap();
        case (pace)
            PACE_BURST:  return 0;
            PACE_SPARSE: return ($urandom_range(0, 49) == 0) ? $urandom_range(1, 19) : 0;
            default:     return $urandom_range(0, 19);
        endcase
    endfunction

    // Fully random pixel, with a bias toward edge codes where the block samples
    function automatic sgm_pkg::pix_t pick_pixel();
        sgm_pkg::pix_t p;
        p = 24'($urandom);
        if (at_block_corner() && $urandom_range(0, 3) == 0) begin
            p.red   = edge_codes[$urandom_range(0, 7)];
            p.green = edge_codes[$urandom_range(0, 7)];
            p.blue  = edge_codes[$urandom_range(0, 7)];
        end
        return p;
    endfunction

    // Send one pixel beat and record the beat it should produce
    task automatic send_pixel(sgm_pkg::pix_t p);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
        mosaic_q.push_back(mosaic_step(p));
    endtask

    task automatic wait_results();
        while (mosaic_q.size() != 0) @(posedge aclk);
    endtask

    // Result side: stall for a drawn number of cycles before each beat
    initial begin
        int unsigned gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Compare each result beat with the oldest expected one
    always @(posedge aclk) begin
        sgm_pkg::res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (mosaic_q.size() == 0) begin
                $error("unexpected result beat: gray %0d frame_last %0d",
                       m_data.gray, m_data.frame_last);
                fail_count++;
            end else begin
                want = mosaic_q.pop_front();
                if (m_data.gray !== want.gray) begin
                    $error("gray mismatch: expected %0d, actual %0d", want.gray, m_data.gray);
                    fail_count++;
                end
                if (m_data.frame_last !== want.frame_last) begin
                    $error("frame_last mismatch: expected %0d, actual %0d",
                           want.frame_last, m_data.frame_last);
                    fail_count++;
                end
            end
        end
    end

    // End the run if nothing moves on either channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[srgb_gray_mosaic_core] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Black, white and red block corners; edge codes everywhere else
    task automatic test_directed_edges();
        sgm_pkg::pix_t p;
        pace = PACE_BURST;
        for (int i = 0; i < 24; i++) begin
            p.red   = edge_codes[$urandom_range(0, 7)];
            p.green = edge_codes[$urandom_range(0, 7)];
            p.blue  = edge_codes[$urandom_range(0, 7)];
            if (i == 0)  p = '{8'd0, 8'd0, 8'd0};
            if (i == 8)  p = '{8'd255, 8'd255, 8'd255};
            if (i == 16) p = '{8'd255, 8'd0, 8'd0};
            send_pixel(p);
        end
    endtask

    // Random pixels in runs of 50, each run with its own pacing
    task automatic test_random_pixels();
        for (int run = 0; run < 12; run++) begin
            pace = pace_t'($urandom_range(0, 2));
            if (run == 0) pace = PACE_RANDOM;
            repeat (50) send_pixel(pick_pixel());
        end
    endtask

    // Hold input until the pipeline has returned every beat
    task automatic test_drain_pause();
        s_valid <= 1'b0;
        wait_results();
    endtask

    // Refill the empty pipeline and keep reading the stored block grays
    task automatic test_resume_after_pause();
        pace = PACE_RANDOM;
        repeat (100) send_pixel(pick_pixel());
    endtask

    initial begin
        build_gamma_tables();
        foreach (block_gray[i]) block_gray[i] = 8'd0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_edges();
        test_random_pixels();
        test_drain_pause();
        test_resume_after_pause();

        s_valid <= 1'b0;
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[srgb_gray_mosaic_core] OK");
        end else begin
            $display("[srgb_gray_mosaic_core] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
